// ----- hdl/efw_pkg.sv -----
package efw_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   localparam int PROD_W   = 2 * WORD_BITS;
   localparam int PACK_W   = PROD_W + 1;
   localparam int NUM_W    = WORD_BITS + FRAC_BITS;
   localparam int QUO_W    = NUM_W + 1;
   localparam int SQ_W     = (NUM_W + 1) / 2;
   localparam int ROOT_W   = SQ_W + 1;
   localparam int DIV_LAT  = NUM_W + 1;
   localparam int SQRT_LAT = SQ_W + 1;

   localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;
   localparam logic [WORD_BITS-1:0] GAMMA_Q = WORD_BITS'((14 * ONE_Q + 5) / 10);
   localparam logic [WORD_BITS-1:0] GM1_Q   = WORD_BITS'((14 * ONE_Q + 5) / 10 - ONE_Q);

   localparam logic [PACK_W-1:0] LIM_NEG  = PACK_W'(1) << (WORD_BITS - 1);
   localparam logic [PACK_W-1:0] LIM_POS  = LIM_NEG - PACK_W'(1);
   localparam logic [PACK_W-1:0] HALF_LSB = PACK_W'(1) << (FRAC_BITS - 1);

   // sign and magnitude, magnitude holds the full negative range
   typedef struct packed {
      logic                 neg;
      logic [WORD_BITS-1:0] mag;
   } sval_type;

   typedef struct packed {
      sval_type v;
      logic     clamp;
   } sat_type;

   // clamp to the word range of the given sign
   function automatic sat_type pack_f(logic neg, logic [PACK_W-1:0] m);
      sat_type             r;
      logic [PACK_W-1:0]   lim;
      lim = neg ? LIM_NEG : LIM_POS;
      if (m > lim) begin
         r.v.mag = lim[WORD_BITS-1:0];
         r.clamp = 1'b1;
      end else begin
         r.v.mag = m[WORD_BITS-1:0];
         r.clamp = 1'b0;
      end
      r.v.neg = neg && (r.v.mag != '0);
      return r;
   endfunction

   // round half away from zero on the magnitude, then clamp
   function automatic sat_type round_f(logic neg, logic [PROD_W-1:0] prod);
      logic [PACK_W-1:0] t;
      t = (PACK_W'(prod) + HALF_LSB) >> FRAC_BITS;
      return pack_f(neg, t);
   endfunction

   function automatic sat_type add_f(sval_type a, sval_type b);
      sat_type r;
      if (a.neg == b.neg) begin
         r = pack_f(a.neg, PACK_W'(a.mag) + PACK_W'(b.mag));
      end else if (a.mag >= b.mag) begin
         r = pack_f(a.neg, PACK_W'(a.mag - b.mag));
      end else begin
         r = pack_f(b.neg, PACK_W'(b.mag - a.mag));
      end
      return r;
   endfunction

   function automatic sval_type negate_f(sval_type a);
      sval_type r;
      r.mag = a.mag;
      r.neg = !a.neg && (a.mag != '0);
      return r;
   endfunction

   function automatic sval_type from_word_f(logic [WORD_BITS-1:0] w);
      sval_type r;
      r.neg = w[WORD_BITS-1];
      r.mag = r.neg ? WORD_BITS'(~w + 1'b1) : w;
      return r;
   endfunction

   function automatic logic [WORD_BITS-1:0] to_word_f(sval_type a);
      return a.neg ? WORD_BITS'(~a.mag + 1'b1) : a.mag;
   endfunction

endpackage

// ----- hdl/efw_req_if.sv -----
interface efw_req_if;
   logic                           valid;
   logic                           ready;
   logic [efw_pkg::WORD_BITS-1:0]  density;
   logic [efw_pkg::WORD_BITS-1:0]  momentum_x;
   logic [efw_pkg::WORD_BITS-1:0]  momentum_y;
   logic [efw_pkg::WORD_BITS-1:0]  total_energy;
   logic                           direction;

   modport source (output valid, density, momentum_x, momentum_y, total_energy, direction,
                   input ready);
   modport sink   (input valid, density, momentum_x, momentum_y, total_energy, direction,
                   output ready);
endinterface

// ----- hdl/efw_rsp_if.sv -----
interface efw_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [efw_pkg::WORD_BITS-1:0]  flux_mass;
   logic [efw_pkg::WORD_BITS-1:0]  flux_mom_x;
   logic [efw_pkg::WORD_BITS-1:0]  flux_mom_y;
   logic [efw_pkg::WORD_BITS-1:0]  flux_energy;
   logic [efw_pkg::WORD_BITS-2:0]  max_speed;
   logic                           zero_density;
   logic                           saturated;

   modport source (output valid, flux_mass, flux_mom_x, flux_mom_y, flux_energy, max_speed,
                   zero_density, saturated, input ready);
   modport sink   (input valid, flux_mass, flux_mom_x, flux_mom_y, flux_energy, max_speed,
                   zero_density, saturated, output ready);
endinterface

// ----- hdl/efw_div.sv -----
// restoring divider, one quotient bit per stage, rounded to nearest
module efw_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [efw_pkg::NUM_W-1:0]     num,
   input  logic [efw_pkg::WORD_BITS-1:0] den,
   output logic [efw_pkg::QUO_W-1:0]     quo
);
   localparam int N = efw_pkg::NUM_W;
   localparam int W = efw_pkg::WORD_BITS;

   logic [N-1:0] num_ff [N];
   logic [N-1:0] q_ff   [N];
   logic [W-1:0] rem_ff [N];
   logic [W-1:0] den_ff [N];
   logic [N-1:0] num_in [N];
   logic [N-1:0] q_in   [N];
   logic [W-1:0] rem_in [N];
   logic [W-1:0] den_in [N];
   logic [N-1:0] num_src [N];
   logic [N-1:0] q_src   [N];
   logic [W-1:0] rem_src [N];
   logic [W:0]   sh      [N];
   logic [efw_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic         round_up;

   always_comb begin
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            num_src[k] = num;
            q_src[k]   = '0;
            rem_src[k] = '0;
            den_in[k]  = den;
         end else begin
            num_src[k] = num_ff[k-1];
            q_src[k]   = q_ff[k-1];
            rem_src[k] = rem_ff[k-1];
            den_in[k]  = den_ff[k-1];
         end
         sh[k]     = {rem_src[k], num_src[k][N-1]};
         num_in[k] = num_src[k] << 1;
         if (sh[k] >= {1'b0, den_in[k]}) begin
            rem_in[k] = W'(sh[k] - {1'b0, den_in[k]});
            q_in[k]   = {q_src[k][N-2:0], 1'b1};
         end else begin
            rem_in[k] = sh[k][W-1:0];
            q_in[k]   = {q_src[k][N-2:0], 1'b0};
         end
      end
      round_up = {rem_ff[N-1], 1'b0} >= {1'b0, den_ff[N-1]};
      quo_in   = efw_pkg::QUO_W'(q_ff[N-1]) + efw_pkg::QUO_W'(round_up);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            num_ff[k] <= num_in[k];
            q_ff[k]   <= q_in[k];
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_in[k];
         end
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;
endmodule

// ----- hdl/efw_sqrt.sv -----
// digit-by-digit square root, one root bit per stage, rounded to nearest
module efw_sqrt (
   input  logic                         clock,
   input  logic                         en,
   input  logic [2*efw_pkg::SQ_W-1:0]   radicand,
   output logic [efw_pkg::ROOT_W-1:0]   root
);
   localparam int S  = efw_pkg::SQ_W;
   localparam int NW = 2 * S;

   logic [NW-1:0] n_ff  [S];
   logic [S-1:0]  r_ff  [S];
   logic [S:0]    rem_ff[S];
   logic [NW-1:0] n_in  [S];
   logic [S-1:0]  r_in  [S];
   logic [S:0]    rem_in[S];
   logic [NW-1:0] n_src [S];
   logic [S-1:0]  r_src [S];
   logic [S:0]    rem_src[S];
   logic [S+2:0]  rem_t [S];
   logic [S+2:0]  trial [S];
   logic [efw_pkg::ROOT_W-1:0] root_ff, root_in;
   logic          round_up;

   always_comb begin
      for (int k = 0; k < S; k++) begin
         if (k == 0) begin
            n_src[k]   = radicand;
            r_src[k]   = '0;
            rem_src[k] = '0;
         end else begin
            n_src[k]   = n_ff[k-1];
            r_src[k]   = r_ff[k-1];
            rem_src[k] = rem_ff[k-1];
         end
         rem_t[k] = {rem_src[k], n_src[k][NW-1:NW-2]};
         trial[k] = (S+3)'({r_src[k], 2'b01});
         n_in[k]  = n_src[k] << 2;
         if (rem_t[k] >= trial[k]) begin
            rem_in[k] = (S+1)'(rem_t[k] - trial[k]);
            r_in[k]   = {r_src[k][S-2:0], 1'b1};
         end else begin
            rem_in[k] = rem_t[k][S:0];
            r_in[k]   = {r_src[k][S-2:0], 1'b0};
         end
      end
      round_up = rem_ff[S-1] > (S+1)'(r_ff[S-1]);
      root_in  = efw_pkg::ROOT_W'(r_ff[S-1]) + efw_pkg::ROOT_W'(round_up);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < S; k++) begin
            n_ff[k]   <= n_in[k];
            r_ff[k]   <= r_in[k];
            rem_ff[k] <= rem_in[k];
         end
         root_ff <= root_in;
      end
   end

   assign root = root_ff;
endmodule

// ----- hdl/euler_flux_and_wave_speed.sv -----
// words are Q16.16 fixed point at the default WORD_BITS and FRAC_BITS
// throughput: one beat per cycle; the whole pipe advances whenever the output register is
//   empty or being taken, so a stall freezes every stage in place
// depth is set by the two chained bit-per-stage dividers and the bit-per-stage square root
// reset: synchronous, clears all stage valid bits and the output valid; data is not reset
module euler_flux_and_wave_speed (
   input  logic           clock,
   input  logic           reset,
   efw_req_if.sink        req_bus,
   efw_rsp_if.source      rsp_bus
);
   localparam int W       = efw_pkg::WORD_BITS;
   localparam int F       = efw_pkg::FRAC_BITS;
   localparam int PW      = efw_pkg::PROD_W;
   localparam int DLAT    = efw_pkg::DIV_LAT;
   localparam int SLAT    = efw_pkg::SQRT_LAT;

   // decoded input beat
   typedef struct packed {
      logic              zero;
      logic              dir;
      efw_pkg::sval_type rho;
      efw_pkg::sval_type mx;
      efw_pkg::sval_type my;
      efw_pkg::sval_type en;
      efw_pkg::sval_type mn;
      logic [W-1:0]      mn_word;
   } base_type;

   // after the first division pair
   typedef struct packed {
      logic              zero;
      logic              dir;
      efw_pkg::sval_type mx;
      efw_pkg::sval_type my;
      efw_pkg::sval_type en;
      logic [W-1:0]      mn_word;
      efw_pkg::sval_type un;
      logic [W-1:0]      un2;
      efw_pkg::sval_type t;
      efw_pkg::sval_type t2;
      logic              flag;
   } st3_type;

   typedef struct packed {
      logic              zero;
      logic              dir;
      logic [W-1:0]      mn_word;
      efw_pkg::sval_type un;
      logic [W-1:0]      un2;
      efw_pkg::sval_type p;
      efw_pkg::sval_type p2;
      efw_pkg::sval_type fx0;
      efw_pkg::sval_type fy0;
      efw_pkg::sval_type fe1;
      logic              flag;
   } st5_type;

   typedef struct packed {
      logic              zero;
      logic [W-1:0]      mn_word;
      logic              un_neg;
      logic              p_neg;
      logic [W-1:0]      un2;
      efw_pkg::sval_type fx;
      efw_pkg::sval_type fy;
      efw_pkg::sval_type fe1;
      logic [PW-1:0]     pup;
      logic [PW-1:0]     pgam;
      logic              flag;
   } st6_type;

   // flux results riding along the wave-speed tail
   typedef struct packed {
      logic              zero;
      logic [W-1:0]      mn_word;
      logic [W-1:0]      un2;
      efw_pkg::sval_type fx;
      efw_pkg::sval_type fy;
      efw_pkg::sval_type fe;
      logic              flag;
   } tail_type;

   typedef struct packed {
      logic [W-1:0]      flux_mass;
      logic [W-1:0]      flux_mom_x;
      logic [W-1:0]      flux_mom_y;
      logic [W-1:0]      flux_energy;
      logic [W-2:0]      max_speed;
      logic              zero_density;
      logic              saturated;
   } rsp_type;

   logic adv;

   // global advance: output slot free or being drained
   logic rsp_valid_ff;
   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // ---------------- stage 0: capture and decode ----------------
   logic     v0_ff;
   base_type b0_ff, b0_in;

   always_comb begin
      b0_in.rho     = efw_pkg::from_word_f(req_bus.density);
      b0_in.mx      = efw_pkg::from_word_f(req_bus.momentum_x);
      b0_in.my      = efw_pkg::from_word_f(req_bus.momentum_y);
      b0_in.en      = efw_pkg::from_word_f(req_bus.total_energy);
      b0_in.dir     = req_bus.direction;
      b0_in.mn      = req_bus.direction ? b0_in.my : b0_in.mx;
      b0_in.mn_word = req_bus.direction ? req_bus.momentum_y : req_bus.momentum_x;
      b0_in.zero    = (req_bus.density == '0);
   end

   // ---------------- stage 1: squares of the momenta ----------------
   logic          v1_ff;
   base_type      b1_ff;
   logic [PW-1:0] sqx_ff, sqy_ff;

   // ---------------- stage 2: kinetic sum s = mx^2 + my^2 ----------------
   logic              v2_ff;
   base_type          b2_ff;
   efw_pkg::sval_type s2_ff, s2_in;
   logic              flag2_ff, flag2_in;
   efw_pkg::sat_type  sqx_r, sqy_r, s_r;

   always_comb begin
      sqx_r    = efw_pkg::round_f(1'b0, sqx_ff);
      sqy_r    = efw_pkg::round_f(1'b0, sqy_ff);
      s_r      = efw_pkg::add_f(sqx_r.v, sqy_r.v);
      s2_in    = s_r.v;
      flag2_in = sqx_r.clamp | sqy_r.clamp | s_r.clamp;
   end

   // ---------------- dividers: s*2^(F-1)/|rho| and m_n*2^F/|rho| ----------------
   logic [efw_pkg::QUO_W-1:0] q_ke, q_un, q_c2;

   efw_div u_div_ke (
      .clock (clock),
      .en    (adv),
      .num   (efw_pkg::NUM_W'(s2_ff.mag) << (F - 1)),
      .den   (b2_ff.rho.mag),
      .quo   (q_ke)
   );

   efw_div u_div_un (
      .clock (clock),
      .en    (adv),
      .num   (efw_pkg::NUM_W'(b2_ff.mn.mag) << F),
      .den   (b2_ff.rho.mag),
      .quo   (q_un)
   );

   logic     sa_v_ff    [DLAT];
   base_type sa_ff      [DLAT];
   logic     sa_flag_ff [DLAT];

   // ---------------- stage 3: signed kinetic terms, E - ke for both paths ----------------
   logic             v3_ff;
   st3_type          b3_ff, b3_in;
   efw_pkg::sat_type ke_r, ke2_r, un_r, un2_r, t_r, t2_r;
   base_type         sa_out;

   always_comb begin
      sa_out = sa_ff[DLAT-1];
      // s is never negative, so the signed quotient takes the sign of rho
      ke_r  = efw_pkg::pack_f(sa_out.rho.neg, efw_pkg::PACK_W'(q_ke));
      ke2_r = efw_pkg::pack_f(1'b0, efw_pkg::PACK_W'(q_ke));
      un_r  = efw_pkg::pack_f(sa_out.mn.neg ^ sa_out.rho.neg, efw_pkg::PACK_W'(q_un));
      un2_r = efw_pkg::pack_f(1'b0, efw_pkg::PACK_W'(q_un));
      t_r   = efw_pkg::add_f(sa_out.en, efw_pkg::negate_f(ke_r.v));
      t2_r  = efw_pkg::add_f(sa_out.en, efw_pkg::negate_f(ke2_r.v));
      b3_in.zero    = sa_out.zero;
      b3_in.dir     = sa_out.dir;
      b3_in.mx      = sa_out.mx;
      b3_in.my      = sa_out.my;
      b3_in.en      = sa_out.en;
      b3_in.mn_word = sa_out.mn_word;
      b3_in.un      = un_r.v;
      b3_in.un2     = un2_r.v.mag;
      b3_in.t       = t_r.v;
      b3_in.t2      = t2_r.v;
      b3_in.flag    = sa_flag_ff[DLAT-1] | ke_r.clamp | ke2_r.clamp | un_r.clamp
                    | un2_r.clamp | t_r.clamp | t2_r.clamp;
   end

   // ---------------- stage 4: products for pressure and flux ----------------
   logic          v4_ff;
   st3_type       b4_ff;
   logic [PW-1:0] pg_ff, pg2_ff, pux_ff, puy_ff, pue_ff;

   // ---------------- stage 5: round pressures and flux terms ----------------
   logic             v5_ff;
   st5_type          b5_ff, b5_in;
   efw_pkg::sat_type p_r, p2_r, fx0_r, fy0_r, fe1_r;

   always_comb begin
      p_r   = efw_pkg::round_f(b4_ff.t.neg, pg_ff);
      p2_r  = efw_pkg::round_f(b4_ff.t2.neg, pg2_ff);
      fx0_r = efw_pkg::round_f(b4_ff.un.neg ^ b4_ff.mx.neg, pux_ff);
      fy0_r = efw_pkg::round_f(b4_ff.un.neg ^ b4_ff.my.neg, puy_ff);
      fe1_r = efw_pkg::round_f(b4_ff.un.neg ^ b4_ff.en.neg, pue_ff);
      b5_in.zero    = b4_ff.zero;
      b5_in.dir     = b4_ff.dir;
      b5_in.mn_word = b4_ff.mn_word;
      b5_in.un      = b4_ff.un;
      b5_in.un2     = b4_ff.un2;
      b5_in.p       = p_r.v;
      b5_in.p2      = p2_r.v;
      b5_in.fx0     = fx0_r.v;
      b5_in.fy0     = fy0_r.v;
      b5_in.fe1     = fe1_r.v;
      b5_in.flag    = b4_ff.flag | p_r.clamp | p2_r.clamp | fx0_r.clamp | fy0_r.clamp
                    | fe1_r.clamp;
   end

   // ---------------- stage 6: pressure on the normal momentum, un*p, gamma*|p2| ----------
   logic             v6_ff;
   st6_type          b6_ff, b6_in;
   efw_pkg::sat_type fxp_r, fyp_r;

   always_comb begin
      fxp_r = efw_pkg::add_f(b5_ff.fx0, b5_ff.p);
      fyp_r = efw_pkg::add_f(b5_ff.fy0, b5_ff.p);
      b6_in.zero    = b5_ff.zero;
      b6_in.mn_word = b5_ff.mn_word;
      b6_in.un_neg  = b5_ff.un.neg;
      b6_in.p_neg   = b5_ff.p.neg;
      b6_in.un2     = b5_ff.un2;
      b6_in.fx      = b5_ff.dir ? b5_ff.fx0 : fxp_r.v;
      b6_in.fy      = b5_ff.dir ? fyp_r.v : b5_ff.fy0;
      b6_in.fe1     = b5_ff.fe1;
      b6_in.pup     = PW'(b5_ff.un.mag) * PW'(b5_ff.p.mag);
      b6_in.pgam    = PW'(efw_pkg::GAMMA_Q) * PW'(b5_ff.p2.mag);
      b6_in.flag    = b5_ff.flag | (b5_ff.dir ? fyp_r.clamp : fxp_r.clamp);
   end

   // ---------------- stage 7: energy flux and gamma*|p2| ----------------
   logic             v7_ff;
   tail_type         b7_ff, b7_in;
   logic [W-1:0]     g7_ff, g7_in;
   efw_pkg::sat_type fe2_r, fe_r, g_r;

   always_comb begin
      fe2_r = efw_pkg::round_f(b6_ff.un_neg ^ b6_ff.p_neg, b6_ff.pup);
      fe_r  = efw_pkg::add_f(b6_ff.fe1, fe2_r.v);
      g_r   = efw_pkg::round_f(1'b0, b6_ff.pgam);
      b7_in.zero    = b6_ff.zero;
      b7_in.mn_word = b6_ff.mn_word;
      b7_in.un2     = b6_ff.un2;
      b7_in.fx      = b6_ff.fx;
      b7_in.fy      = b6_ff.fy;
      b7_in.fe      = fe_r.v;
      b7_in.flag    = b6_ff.flag | fe2_r.clamp | fe_r.clamp | g_r.clamp;
      g7_in         = g_r.v.mag;
   end

   // |rho| has to ride along to the second divider; keep it in a small side line
   logic [W-1:0] rho3_ff, rho4_ff, rho5_ff, rho6_ff, rho7_ff;

   // ---------------- divider: c^2 = gamma*|p2| * 2^F / |rho| ----------------
   efw_div u_div_c2 (
      .clock (clock),
      .en    (adv),
      .num   (efw_pkg::NUM_W'(g7_ff) << F),
      .den   (rho7_ff),
      .quo   (q_c2)
   );

   logic     sb_v_ff [DLAT];
   tail_type sb_ff   [DLAT];

   // ---------------- stage 8: clamp c^2 ----------------
   logic             v8_ff;
   tail_type         b8_ff, b8_in;
   logic [W-1:0]     c2_ff;
   efw_pkg::sat_type c2_r;

   always_comb begin
      c2_r       = efw_pkg::pack_f(1'b0, efw_pkg::PACK_W'(q_c2));
      b8_in      = sb_ff[DLAT-1];
      b8_in.flag = sb_ff[DLAT-1].flag | c2_r.clamp;
   end

   // ---------------- square root of c^2 * 2^F ----------------
   logic [efw_pkg::ROOT_W-1:0] c_root;

   efw_sqrt u_sqrt (
      .clock    (clock),
      .en       (adv),
      .radicand ((2*efw_pkg::SQ_W)'(c2_ff) << F),
      .root     (c_root)
   );

   logic     sc_v_ff [SLAT];
   tail_type sc_ff   [SLAT];

   // ---------------- output register ----------------
   rsp_type    rsp_ff, rsp_in;
   tail_type   sc_out;
   logic [W:0] spd_sum;
   logic       spd_clamp;

   always_comb begin
      sc_out    = sc_ff[SLAT-1];
      spd_sum   = (W+1)'(sc_out.un2) + (W+1)'(c_root);
      spd_clamp = spd_sum > efw_pkg::LIM_POS[W:0];
      if (sc_out.zero) begin
         rsp_in              = '0;
         rsp_in.zero_density = 1'b1;
      end else begin
         rsp_in.flux_mass    = sc_out.mn_word;
         rsp_in.flux_mom_x   = efw_pkg::to_word_f(sc_out.fx);
         rsp_in.flux_mom_y   = efw_pkg::to_word_f(sc_out.fy);
         rsp_in.flux_energy  = efw_pkg::to_word_f(sc_out.fe);
         rsp_in.max_speed    = spd_clamp ? efw_pkg::LIM_POS[W-2:0] : spd_sum[W-2:0];
         rsp_in.zero_density = 1'b0;
         rsp_in.saturated    = sc_out.flag | spd_clamp;
      end
   end

   // ---------------- valid bits ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < DLAT; k++) begin
            sa_v_ff[k] <= 1'b0;
            sb_v_ff[k] <= 1'b0;
         end
         for (int k = 0; k < SLAT; k++) begin
            sc_v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         v0_ff <= req_bus.valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         sa_v_ff[0] <= v2_ff;
         for (int k = 1; k < DLAT; k++) begin
            sa_v_ff[k] <= sa_v_ff[k-1];
         end
         v3_ff <= sa_v_ff[DLAT-1];
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         sb_v_ff[0] <= v7_ff;
         for (int k = 1; k < DLAT; k++) begin
            sb_v_ff[k] <= sb_v_ff[k-1];
         end
         v8_ff <= sb_v_ff[DLAT-1];
         sc_v_ff[0] <= v8_ff;
         for (int k = 1; k < SLAT; k++) begin
            sc_v_ff[k] <= sc_v_ff[k-1];
         end
         rsp_valid_ff <= sc_v_ff[SLAT-1];
      end
   end

   // ---------------- data path registers ----------------
   always_ff @(posedge clock) begin
      if (adv) begin
         b0_ff  <= b0_in;
         b1_ff  <= b0_ff;
         sqx_ff <= PW'(b0_ff.mx.mag) * PW'(b0_ff.mx.mag);
         sqy_ff <= PW'(b0_ff.my.mag) * PW'(b0_ff.my.mag);
         b2_ff    <= b1_ff;
         s2_ff    <= s2_in;
         flag2_ff <= flag2_in;
         sa_ff[0]      <= b2_ff;
         sa_flag_ff[0] <= flag2_ff;
         for (int k = 1; k < DLAT; k++) begin
            sa_ff[k]      <= sa_ff[k-1];
            sa_flag_ff[k] <= sa_flag_ff[k-1];
         end
         b3_ff   <= b3_in;
         rho3_ff <= sa_out.rho.mag;
         b4_ff   <= b3_ff;
         rho4_ff <= rho3_ff;
         pg_ff   <= PW'(efw_pkg::GM1_Q) * PW'(b3_ff.t.mag);
         pg2_ff  <= PW'(efw_pkg::GM1_Q) * PW'(b3_ff.t2.mag);
         pux_ff  <= PW'(b3_ff.un.mag) * PW'(b3_ff.mx.mag);
         puy_ff  <= PW'(b3_ff.un.mag) * PW'(b3_ff.my.mag);
         pue_ff  <= PW'(b3_ff.un.mag) * PW'(b3_ff.en.mag);
         b5_ff   <= b5_in;
         rho5_ff <= rho4_ff;
         b6_ff   <= b6_in;
         rho6_ff <= rho5_ff;
         b7_ff   <= b7_in;
         g7_ff   <= g7_in;
         rho7_ff <= rho6_ff;
         sb_ff[0] <= b7_ff;
         for (int k = 1; k < DLAT; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
         b8_ff <= b8_in;
         c2_ff <= c2_r.v.mag;
         sc_ff[0] <= b8_ff;
         for (int k = 1; k < SLAT; k++) begin
            sc_ff[k] <= sc_ff[k-1];
         end
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.flux_mass    = rsp_ff.flux_mass;
   assign rsp_bus.flux_mom_x   = rsp_ff.flux_mom_x;
   assign rsp_bus.flux_mom_y   = rsp_ff.flux_mom_y;
   assign rsp_bus.flux_energy  = rsp_ff.flux_energy;
   assign rsp_bus.max_speed    = rsp_ff.max_speed;
   assign rsp_bus.zero_density = rsp_ff.zero_density;
   assign rsp_bus.saturated    = rsp_ff.saturated;

endmodule
